// ----- rtl/core/fdp_pkg.sv -----
// Shared types, constants and binary32 helper functions for the float dot product block.
package fdp_pkg;

	localparam int LANES_DEF = 8;
	localparam int TAG_W_DEF = 5;

	localparam int EXP_W  = 11;
	localparam int MAN_W  = 24;
	localparam int PROD_W = 48;
	localparam int WIN_W  = 64;
	localparam int WSH_W  = 6;
	localparam int SUM_W  = 65;
	localparam int MSB_W  = 7;

	typedef logic [1:0] dest_t;
	localparam dest_t DEST_LANE = 2'd0;
	localparam dest_t DEST_SUM  = 2'd1;
	localparam dest_t DEST_OUT  = 2'd2;

	localparam logic [31:0] ONE_F32      = 32'h3F80_0000;
	localparam logic [31:0] QNAN_DEFAULT = 32'hFFC0_0000;
	localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;
	localparam logic [31:0] INF_MAG      = 32'h7F80_0000;

	typedef logic signed [EXP_W-1:0] exp_t;
	localparam exp_t E_BIAS       = 11'sd150;
	localparam exp_t E_MANT       = 11'sd23;
	localparam exp_t E_MIN_LSB    = -11'sd149;
	localparam exp_t E_PROD_PAD   = 11'sd16;
	localparam exp_t E_ADD_PAD    = 11'sd40;
	localparam exp_t E_SH_MAX     = 11'sd66;
	localparam exp_t E_ZERO       = 11'sd0;
	localparam exp_t E_ONE        = 11'sd1;
	localparam exp_t E_MAX_BIASED = 11'sd255;

	typedef struct packed {
		logic [MAN_W-1:0] man;
		exp_t             expo;
	} unpk_t;

	function automatic logic is_nan(input logic [31:0] x);
		return x[30:0] > INF_MAG[30:0];
	endfunction

	function automatic logic is_inf(input logic [31:0] x);
		return x[30:0] == INF_MAG[30:0];
	endfunction

	function automatic logic is_zero(input logic [31:0] x);
		return x[30:0] == 31'd0;
	endfunction

	// Significand with its top bit at bit 23, and the exponent of its lsb.
	function automatic unpk_t unpack_norm(input logic [31:0] x);
		logic [MAN_W-1:0] m;
		logic [7:0]       ex;
		logic [4:0]       lz;
		int               top;
		unpk_t            r;
		ex  = x[30:23];
		m   = {(ex != 8'd0), x[22:0]};
		top = 0;
		for (int i = 0; i < MAN_W; i++) begin
			if (m[i])
				top = i;
		end
		lz     = 5'(MAN_W - 1 - top);
		r.man  = m << lz;
		r.expo = $signed({3'b000, (ex == 8'd0) ? 8'd1 : ex}) - E_BIAS
			- $signed({6'b000000, lz});
		return r;
	endfunction

	// Right shift that ORs every bit shifted out into the lsb.
	function automatic logic [WIN_W-1:0] jam_shr(input logic [WIN_W-1:0] x,
		input logic [EXP_W-1:0] amt);
		logic [WIN_W-1:0] r;
		logic [WIN_W-1:0] mask;
		r    = '0;
		mask = '0;
		if (amt >= EXP_W'(WIN_W)) begin
			r[0] = |x;
		end else begin
			mask = ~({WIN_W{1'b1}} << amt[WSH_W-1:0]);
			r    = x >> amt[WSH_W-1:0];
			r[0] = r[0] | (|(x & mask));
		end
		return r;
	endfunction

	function automatic logic [MSB_W-1:0] msb_sum(input logic [SUM_W-1:0] s);
		logic [MSB_W-1:0] m;
		m = '0;
		for (int i = 0; i < SUM_W; i++) begin
			if (s[i])
				m = MSB_W'(i);
		end
		return m;
	endfunction

endpackage

// ----- rtl/core/fdp_fma.sv -----
// Seven-stage binary32 fused multiply-add pipeline with a tag carried alongside each beat.
module fdp_fma #(
	parameter int TAG_W = fdp_pkg::TAG_W_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [31:0]      in_a,
	input  logic [31:0]      in_b,
	input  logic [31:0]      in_c,
	input  logic [TAG_W-1:0] in_tag,
	output logic             out_valid,
	output logic [31:0]      out_res,
	output logic [TAG_W-1:0] out_tag
);

	localparam int MAN_W = fdp_pkg::MAN_W;
	localparam int QW    = MAN_W + 1;

	// stage 1: classify and unpack
	logic        spec_c;
	logic [31:0] sval_c;
	logic        sp_c;
	fdp_pkg::unpk_t ua_c, ub_c, uc_c;

	logic                   v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [TAG_W-1:0]       tag_s1, tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic                   spec_s1, spec_s2, spec_s3, spec_s4, spec_s5, spec_s6;
	logic [31:0]            sval_s1, sval_s2, sval_s3, sval_s4, sval_s5, sval_s6;
	logic                   sp_s1, sp_s2, sp_s3;
	logic                   sc_s1, sc_s2, sc_s3;
	logic                   cz_s1, cz_s2;
	logic [MAN_W-1:0]       ma_s1, mb_s1, mc_s1, mc_s2;
	fdp_pkg::exp_t          ea_s1, eb_s1, ec_s1, ec_s2, ep_s2;
	logic [fdp_pkg::PROD_W-1:0] p_s2;
	logic [fdp_pkg::WIN_W-1:0]  pal_s3, cal_s3;
	fdp_pkg::exp_t          e_s3, e_s4, e_s5;
	logic [fdp_pkg::SUM_W-1:0]  s_s4, s_s5;
	logic                   sgn_s4, sgn_s5, sgn_s6;
	logic [fdp_pkg::MSB_W-1:0]  m_s5;
	logic                   zero_s5, zero_s6;
	logic [MAN_W-1:0]       q_s6;
	logic                   rnd_s6, stk_s6;
	fdp_pkg::exp_t          lsb_s6;
	logic [31:0]            res_s7;

	always_comb begin
		sp_c   = in_a[31] ^ in_b[31];
		spec_c = 1'b1;
		sval_c = '0;
		if (fdp_pkg::is_nan(in_a)) begin
			sval_c = in_a | fdp_pkg::QUIET_BIT;
		end else if (fdp_pkg::is_nan(in_b)) begin
			sval_c = in_b | fdp_pkg::QUIET_BIT;
		end else if (fdp_pkg::is_nan(in_c)) begin
			sval_c = in_c | fdp_pkg::QUIET_BIT;
		end else if (fdp_pkg::is_inf(in_a) || fdp_pkg::is_inf(in_b)) begin
			if (fdp_pkg::is_zero(in_a) || fdp_pkg::is_zero(in_b))
				sval_c = fdp_pkg::QNAN_DEFAULT;
			else if (fdp_pkg::is_inf(in_c) && (in_c[31] != sp_c))
				sval_c = fdp_pkg::QNAN_DEFAULT;
			else
				sval_c = {sp_c, fdp_pkg::INF_MAG[30:0]};
		end else if (fdp_pkg::is_inf(in_c)) begin
			sval_c = in_c;
		end else if (fdp_pkg::is_zero(in_a) || fdp_pkg::is_zero(in_b)) begin
			if (fdp_pkg::is_zero(in_c))
				sval_c = {sp_c & in_c[31], 31'd0};
			else
				sval_c = in_c;
		end else begin
			spec_c = 1'b0;
		end
		ua_c = fdp_pkg::unpack_norm(in_a);
		ub_c = fdp_pkg::unpack_norm(in_b);
		uc_c = fdp_pkg::unpack_norm(in_c);
	end

	// stage 3: normalize product and align
	logic [fdp_pkg::PROD_W-1:0] pn_c;
	fdp_pkg::exp_t              epn_c, ep_c, ecx_c, d_c, nd_c;
	logic [fdp_pkg::WIN_W-1:0]  pw_c, cw_c, pal_c, cal_c;
	fdp_pkg::exp_t              e3_c;

	always_comb begin
		pn_c  = p_s2[fdp_pkg::PROD_W-1] ? p_s2 : (p_s2 << 1);
		epn_c = p_s2[fdp_pkg::PROD_W-1] ? ep_s2 : (ep_s2 - fdp_pkg::E_ONE);
		pw_c  = {pn_c, 16'd0};
		cw_c  = {mc_s2, 40'd0};
		ep_c  = epn_c - fdp_pkg::E_PROD_PAD;
		ecx_c = ec_s2 - fdp_pkg::E_ADD_PAD;
		d_c   = ep_c - ecx_c;
		nd_c  = fdp_pkg::E_ZERO - d_c;
		if (cz_s2) begin
			pal_c = pw_c;
			cal_c = '0;
			e3_c  = ep_c;
		end else if (d_c >= fdp_pkg::E_ZERO) begin
			pal_c = pw_c;
			cal_c = fdp_pkg::jam_shr(cw_c, d_c);
			e3_c  = ep_c;
		end else begin
			pal_c = fdp_pkg::jam_shr(pw_c, nd_c);
			cal_c = cw_c;
			e3_c  = ecx_c;
		end
	end

	// stage 4: add or subtract magnitudes
	logic [fdp_pkg::SUM_W-1:0] s_c;
	logic                      sgn_c;

	always_comb begin
		if (sp_s3 == sc_s3) begin
			s_c   = {1'b0, pal_s3} + {1'b0, cal_s3};
			sgn_c = sp_s3;
		end else if (pal_s3 >= cal_s3) begin
			s_c   = {1'b0, pal_s3} - {1'b0, cal_s3};
			sgn_c = sp_s3;
		end else begin
			s_c   = {1'b0, cal_s3} - {1'b0, pal_s3};
			sgn_c = sc_s3;
		end
	end

	// stage 6: pick the rounding position, clamped at the subnormal lsb
	fdp_pkg::exp_t             sha_c, lim_c, sh_c;
	logic [fdp_pkg::MSB_W-1:0] shu_c;
	logic [4:0]                nsh_c;
	logic [MAN_W-1:0]          q_c;
	logic                      rnd_c, stk_c;

	always_comb begin
		sha_c = $signed({4'b0000, m_s5}) - fdp_pkg::E_MANT;
		lim_c = fdp_pkg::E_MIN_LSB - e_s5;
		sh_c  = (sha_c < lim_c) ? lim_c : sha_c;
		nsh_c = 5'(fdp_pkg::E_ZERO - sh_c);
		shu_c = fdp_pkg::MSB_W'(sh_c);
		q_c   = '0;
		rnd_c = 1'b0;
		stk_c = 1'b0;
		if (sh_c <= fdp_pkg::E_ZERO) begin
			q_c = MAN_W'(s_s5 << nsh_c);
		end else if (sh_c >= fdp_pkg::E_SH_MAX) begin
			stk_c = 1'b1;
		end else begin
			q_c   = MAN_W'(s_s5 >> shu_c);
			rnd_c = s_s5[shu_c - 1'b1];
			stk_c = |(s_s5 & ((fdp_pkg::SUM_W'(1) << (shu_c - 1'b1))
				- fdp_pkg::SUM_W'(1)));
		end
	end

	// stage 7: round to nearest even and pack
	logic [QW-1:0]  q2_c;
	fdp_pkg::exp_t  lsb2_c, biased_c;
	logic           inc_c;
	logic [31:0]    res_c;

	always_comb begin
		inc_c  = rnd_s6 && (stk_s6 || q_s6[0]);
		q2_c   = {1'b0, q_s6} + QW'(inc_c);
		lsb2_c = lsb_s6;
		if (q2_c[MAN_W]) begin
			q2_c   = q2_c >> 1;
			lsb2_c = lsb_s6 + fdp_pkg::E_ONE;
		end
		biased_c = lsb2_c + fdp_pkg::E_BIAS;
		if (spec_s6)
			res_c = sval_s6;
		else if (zero_s6)
			res_c = '0;
		else if (q2_c[MAN_W-1]) begin
			if (biased_c >= fdp_pkg::E_MAX_BIASED)
				res_c = {sgn_s6, fdp_pkg::INF_MAG[30:0]};
			else
				res_c = {sgn_s6, biased_c[7:0], q2_c[22:0]};
		end else
			res_c = {sgn_s6, 8'd0, q2_c[22:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		tag_s1  <= in_tag;
		spec_s1 <= spec_c;
		sval_s1 <= sval_c;
		sp_s1   <= sp_c;
		sc_s1   <= in_c[31];
		cz_s1   <= fdp_pkg::is_zero(in_c);
		ma_s1   <= ua_c.man;
		mb_s1   <= ub_c.man;
		mc_s1   <= uc_c.man;
		ea_s1   <= ua_c.expo;
		eb_s1   <= ub_c.expo;
		ec_s1   <= uc_c.expo;

		tag_s2  <= tag_s1;
		spec_s2 <= spec_s1;
		sval_s2 <= sval_s1;
		sp_s2   <= sp_s1;
		sc_s2   <= sc_s1;
		cz_s2   <= cz_s1;
		p_s2    <= ma_s1 * mb_s1;
		ep_s2   <= ea_s1 + eb_s1;
		mc_s2   <= mc_s1;
		ec_s2   <= ec_s1;

		tag_s3  <= tag_s2;
		spec_s3 <= spec_s2;
		sval_s3 <= sval_s2;
		sp_s3   <= sp_s2;
		sc_s3   <= sc_s2;
		pal_s3  <= pal_c;
		cal_s3  <= cal_c;
		e_s3    <= e3_c;

		tag_s4  <= tag_s3;
		spec_s4 <= spec_s3;
		sval_s4 <= sval_s3;
		s_s4    <= s_c;
		sgn_s4  <= sgn_c;
		e_s4    <= e_s3;

		tag_s5  <= tag_s4;
		spec_s5 <= spec_s4;
		sval_s5 <= sval_s4;
		s_s5    <= s_s4;
		sgn_s5  <= sgn_s4;
		e_s5    <= e_s4;
		m_s5    <= fdp_pkg::msb_sum(s_s4);
		zero_s5 <= (s_s4 == '0);

		tag_s6  <= tag_s5;
		spec_s6 <= spec_s5;
		sval_s6 <= sval_s5;
		sgn_s6  <= sgn_s5;
		zero_s6 <= zero_s5;
		q_s6    <= q_c;
		rnd_s6  <= rnd_c;
		stk_s6  <= stk_c;
		lsb_s6  <= e_s5 + sh_c;

		tag_s7  <= tag_s6;
		res_s7  <= res_c;
	end

	assign out_valid = v_s7;
	assign out_res   = res_s7;
	assign out_tag   = tag_s7;

endmodule

// ----- rtl/core/float_dot_product_8lane_fma.sv -----
// Interleaved-lane binary32 dot product built around one seven-stage FMA pipeline.
// Each element pair is fused into lane (count mod LANES) with one rounding to nearest even.
// A lane takes its next pair only after its previous one has passed the seven FMA stages and
// the lane write-back: with LANES of 8 or more one pair is taken every cycle while the block
// accumulates, with fewer lanes in_stall is held while the next lane is still busy. After the
// pair marked last, in_stall stays high while in-flight pairs drain and the lanes are summed in
// order through the same pipeline, one lane after another, before the next vector is taken.
// The sum waits in an output register; a new vector streams in while it is held, but the next
// final add does not start until that register has been taken.
module float_dot_product_8lane_fma #(
	parameter int LANES = fdp_pkg::LANES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] a_value,
	input  logic [31:0] b_value,
	input  logic        last_item,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] dot_result
);

	localparam int IW    = (LANES > 1) ? $clog2(LANES) : 1;
	localparam int TAG_W = 2 + IW;

	localparam logic [1:0] ST_ACC  = 2'd0;
	localparam logic [1:0] ST_WAIT = 2'd1;
	localparam logic [1:0] ST_RED  = 2'd2;
	localparam logic [1:0] ST_OUTW = 2'd3;

	logic [1:0]        state_q;
	logic [31:0]       lane_sum_q [LANES];
	logic [LANES-1:0]  busy_q;
	logic [IW-1:0]     lane_q;
	logic [IW-1:0]     red_idx_q;
	logic [31:0]       sum_q;
	logic              sum_rdy_q;
	logic              out_valid_q;
	logic [31:0]       out_data_q;

	logic              acc;
	logic              red_mode;
	logic              red_last;
	logic              red_go;
	logic [IW-1:0]     rd_idx;
	fdp_pkg::dest_t    iss_dest;
	logic [TAG_W-1:0]  iss_tag;
	logic              f_valid;
	logic [31:0]       f_res;
	logic [TAG_W-1:0]  f_tag;
	fdp_pkg::dest_t    f_dest;
	logic [IW-1:0]     f_lane;
	logic              wb;

	assign in_stall = (state_q != ST_ACC) || busy_q[lane_q];
	assign acc      = in_valid && !in_stall;
	assign red_mode = (state_q == ST_RED);
	assign red_last = (red_idx_q == IW'(LANES - 1));
	// hold the final add until the output register is free
	assign red_go   = red_mode && sum_rdy_q && (!red_last || !out_valid_q);
	assign rd_idx   = red_mode ? red_idx_q : lane_q;
	assign iss_dest = acc ? fdp_pkg::DEST_LANE
		: (red_last ? fdp_pkg::DEST_OUT : fdp_pkg::DEST_SUM);
	assign iss_tag  = {iss_dest, rd_idx};

	fdp_fma #(
		.TAG_W(TAG_W)
	) u_fma (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (acc || red_go),
		.in_a     (red_mode ? sum_q : a_value),
		.in_b     (red_mode ? fdp_pkg::ONE_F32 : b_value),
		.in_c     (lane_sum_q[rd_idx]),
		.in_tag   (iss_tag),
		.out_valid(f_valid),
		.out_res  (f_res),
		.out_tag  (f_tag)
	);

	assign f_dest = f_tag[TAG_W-1 -: 2];
	assign f_lane = f_tag[IW-1:0];
	assign wb     = f_valid && (f_dest == fdp_pkg::DEST_LANE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LANES; i++)
				lane_sum_q[i] <= '0;
			busy_q <= '0;
		end else begin
			for (int i = 0; i < LANES; i++) begin
				if (red_go && red_last)
					lane_sum_q[i] <= '0;
				else if (wb && (f_lane == IW'(i)))
					lane_sum_q[i] <= f_res;
				if (wb && (f_lane == IW'(i)))
					busy_q[i] <= 1'b0;
				else if (acc && (lane_q == IW'(i)))
					busy_q[i] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_ACC;
			lane_q      <= '0;
			red_idx_q   <= '0;
			sum_q       <= '0;
			sum_rdy_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (acc)
				lane_q <= (lane_q == IW'(LANES - 1)) ? '0 : lane_q + 1'b1;
			if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_ACC: begin
					if (acc && last_item)
						state_q <= ST_WAIT;
				end
				ST_WAIT: begin
					if (busy_q == '0) begin
						state_q   <= ST_RED;
						red_idx_q <= '0;
						sum_q     <= '0;
						sum_rdy_q <= 1'b1;
					end
				end
				ST_RED: begin
					if (red_go) begin
						sum_rdy_q <= 1'b0;
						if (red_last) begin
							state_q <= ST_OUTW;
							lane_q  <= '0;
						end
					end
					if (f_valid && (f_dest == fdp_pkg::DEST_SUM)) begin
						sum_q     <= f_res;
						sum_rdy_q <= 1'b1;
						red_idx_q <= red_idx_q + 1'b1;
					end
				end
				ST_OUTW: begin
					if (f_valid && (f_dest == fdp_pkg::DEST_OUT)) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_ACC;
					end
				end
				default: state_q <= ST_ACC;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (f_valid && (f_dest == fdp_pkg::DEST_OUT))
			out_data_q <= f_res;
	end

	assign out_valid  = out_valid_q;
	assign dot_result = out_data_q;

endmodule

// ----- rtl/core/fdp_checker.sv -----
// Port-level checks for the float dot product block, bound to its top level.
module fdp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        last_item,
	input logic        out_valid,
	input logic        out_stall,
	input logic [31:0] dot_result
);

	// a held result beat keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(dot_result))
		else $error("result beat changed while stalled");

	// the final beat of a vector closes the input until the sum is formed
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_item |=> in_stall)
		else $error("input open right after last beat");

	// a result only appears at the end of a reduction, when input was closed
	a_out_from_red: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result appeared outside a reduction");

endmodule

bind float_dot_product_8lane_fma fdp_checker u_fdp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.last_item (last_item),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.dot_result(dot_result)
);
